// ===== hdl/gbl_pkg.sv =====
// ----------------------------------------------------------------------------
// gbl_pkg
// command and status codes and the result record shared by the line editor
// ----------------------------------------------------------------------------
package gbl_pkg;

  localparam int CMD_W = 3;
  localparam int CH_W  = 8;
  localparam int IDX_W = 10;
  localparam int CNT_W = 11;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_LEFT   = 3'd1,
    CMD_RIGHT  = 3'd2,
    CMD_BKSP   = 3'd3,
    CMD_DELETE = 3'd4,
    CMD_READ   = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EDGE  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    status_t           status;
    logic [CH_W-1:0]   read_char;
    logic [CNT_W-1:0]  cursor_out;
    logic [CNT_W-1:0]  used_count;
  } result_t;

endpackage

// ===== hdl/gbl_store.sv =====
// ----------------------------------------------------------------------------
// gbl_store
// single-port character store, one access per cycle, registered read data
// ----------------------------------------------------------------------------
module gbl_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic                      we,
  input  logic [AW-1:0]             addr,
  input  logic [gbl_pkg::CH_W-1:0]  wdata,
  output logic [gbl_pkg::CH_W-1:0]  rdata
);
  import gbl_pkg::*;

  logic [CH_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ===== hdl/gbl_ctrl.sv =====
// ----------------------------------------------------------------------------
// gbl_ctrl
// command sequencer: holds cursor and gap end, drives the store port
// ----------------------------------------------------------------------------
module gbl_ctrl #(
  parameter int CAPACITY = 1024,
  parameter int AW       = 10,
  parameter int PW       = 11
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [gbl_pkg::CMD_W-1:0]  cmd,
  input  logic [gbl_pkg::CH_W-1:0]   ch,
  input  logic [gbl_pkg::IDX_W-1:0]  read_index,
  input  logic                       res_ready,
  output logic                       res_valid,
  output gbl_pkg::result_t           res,
  output logic                       mem_en,
  output logic                       mem_we,
  output logic [AW-1:0]              mem_addr,
  output logic [gbl_pkg::CH_W-1:0]   mem_wdata,
  input  logic [gbl_pkg::CH_W-1:0]   mem_rdata
);
  import gbl_pkg::*;

  localparam int XW = ((PW > IDX_W) ? PW : IDX_W) + 1;

  typedef enum logic {S_IDLE, S_FINISH} state_t;

  state_t         state;
  logic [PW-1:0]  cursor;
  logic [PW-1:0]  gap_end;
  cmd_t           cmd_q;
  status_t        status_q;

  logic [PW-1:0]  cursor_next;
  logic [PW-1:0]  gap_end_next;
  status_t        status_new;
  logic [XW-1:0]  cur_x;
  logic [XW-1:0]  gap_x;
  logic [XW-1:0]  idx_x;
  logic [XW-1:0]  used_x;
  logic [XW-1:0]  far_addr_x;
  logic [XW-1:0]  used_next_x;
  logic           at_start;
  logic           at_end;
  logic           accept;
  logic           finish;
  logic           ok_q;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && (state == S_IDLE);
  assign finish    = (state == S_FINISH) && res_ready;
  assign res_valid = finish;
  assign ok_q      = (status_q == ST_OK);

  assign cur_x      = XW'(cursor);
  assign gap_x      = XW'(gap_end);
  assign idx_x      = XW'(read_index);
  assign used_x     = cur_x + XW'(CAPACITY) - gap_x;
  assign far_addr_x = gap_x + idx_x - cur_x;
  assign at_start   = (cursor == '0);
  assign at_end     = (gap_end == PW'(CAPACITY));

  // status of the incoming command from the current edit state
  always_comb begin
    unique case (cmd_t'(cmd))
      CMD_INSERT: status_new = (cursor >= gap_end) ? ST_FULL : ST_OK;
      CMD_LEFT,
      CMD_BKSP:   status_new = at_start ? ST_EDGE : ST_OK;
      CMD_RIGHT,
      CMD_DELETE: status_new = at_end ? ST_EDGE : ST_OK;
      CMD_READ:   status_new = (idx_x >= used_x) ? ST_RANGE : ST_OK;
      default:    status_new = ST_EDGE;
    endcase
  end

  // store port: the accepting cycle serves the command, the finishing cycle writes back a move
  always_comb begin
    mem_en    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = '0;
    mem_wdata = mem_rdata;
    if (accept && (status_new == ST_OK)) begin
      unique case (cmd_t'(cmd))
        CMD_INSERT: begin
          mem_en    = 1'b1;
          mem_we    = 1'b1;
          mem_addr  = cursor[AW-1:0];
          mem_wdata = ch;
        end
        CMD_LEFT: begin
          mem_en   = 1'b1;
          mem_addr = AW'(cursor - PW'(1));
        end
        CMD_RIGHT: begin
          mem_en   = 1'b1;
          mem_addr = gap_end[AW-1:0];
        end
        CMD_READ: begin
          mem_en   = 1'b1;
          mem_addr = (idx_x < cur_x) ? read_index[AW-1:0] : far_addr_x[AW-1:0];
        end
        default: begin
          mem_en = 1'b0;
        end
      endcase
    end else if (finish && ok_q) begin
      unique case (cmd_q)
        CMD_LEFT: begin
          mem_en   = 1'b1;
          mem_we   = 1'b1;
          mem_addr = AW'(gap_end - PW'(1));
        end
        CMD_RIGHT: begin
          mem_en   = 1'b1;
          mem_we   = 1'b1;
          mem_addr = cursor[AW-1:0];
        end
        default: begin
          mem_en = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    cursor_next  = cursor;
    gap_end_next = gap_end;
    if (ok_q) begin
      unique case (cmd_q)
        CMD_INSERT: cursor_next = cursor + PW'(1);
        CMD_LEFT: begin
          cursor_next  = cursor - PW'(1);
          gap_end_next = gap_end - PW'(1);
        end
        CMD_RIGHT: begin
          cursor_next  = cursor + PW'(1);
          gap_end_next = gap_end + PW'(1);
        end
        CMD_BKSP:   cursor_next  = cursor - PW'(1);
        CMD_DELETE: gap_end_next = gap_end + PW'(1);
        default:    cursor_next  = cursor;
      endcase
    end
  end

  assign used_next_x = XW'(cursor_next) + XW'(CAPACITY) - XW'(gap_end_next);

  assign res.status     = status_q;
  assign res.read_char  = ((cmd_q == CMD_READ) && ok_q) ? mem_rdata : '0;
  assign res.cursor_out = CNT_W'(XW'(cursor_next));
  assign res.used_count = CNT_W'(used_next_x);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cursor   <= '0;
      gap_end  <= PW'(CAPACITY);
      cmd_q    <= CMD_INSERT;
      status_q <= ST_OK;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cmd_q    <= cmd_t'(cmd);
            status_q <= status_new;
            state    <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (finish) begin
            cursor  <= cursor_next;
            gap_end <= gap_end_next;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/gap_buffer_line_editor.sv =====
// ----------------------------------------------------------------------------
// gap_buffer_line_editor
// fixed-capacity gap buffer for one line of text
// ----------------------------------------------------------------------------
// Each command is served in a transfer cycle and a finishing cycle. In the
// transfer cycle the single-port store serves the command (insert writes,
// moves and reads fetch one character); in the finishing cycle, held off
// while the output register is stalled, a move writes its character back
// across the gap and the result is loaded into the output register. One
// command is in work at a time; a new one is taken while the previous result
// still waits there. The store needs no clearing, so the block is ready out of reset.
module gap_buffer_line_editor #(
  parameter int CAPACITY = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [gbl_pkg::CMD_W-1:0]  cmd,
  input  logic [gbl_pkg::CH_W-1:0]   ch,
  input  logic [gbl_pkg::IDX_W-1:0]  read_index,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 status,
  output logic [gbl_pkg::CH_W-1:0]   read_char,
  output logic [gbl_pkg::CNT_W-1:0]  cursor_out,
  output logic [gbl_pkg::CNT_W-1:0]  used_count
);
  import gbl_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int PW = $clog2(CAPACITY + 1);

  logic             res_ready;
  logic             res_valid;
  result_t          res;
  result_t          out_q;
  logic             mem_en;
  logic             mem_we;
  logic [AW-1:0]    mem_addr;
  logic [CH_W-1:0]  mem_wdata;
  logic [CH_W-1:0]  mem_rdata;

  gbl_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .PW       (PW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .ch         (ch),
    .read_index (read_index),
    .res_ready  (res_ready),
    .res_valid  (res_valid),
    .res        (res),
    .mem_en     (mem_en),
    .mem_we     (mem_we),
    .mem_addr   (mem_addr),
    .mem_wdata  (mem_wdata),
    .mem_rdata  (mem_rdata)
  );

  gbl_store #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // output register, free once its transfer completes
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign status     = out_q.status;
  assign read_char  = out_q.read_char;
  assign cursor_out = out_q.cursor_out;
  assign used_count = out_q.used_count;

endmodule
